// ----- rtl/mayb_pkg.sv -----
// Shared constants and pipeline stage types for the masked additive YUV blend.
// No dependencies; compile first.
package mayb_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned OPAC_W     = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE = 1'd1;

  localparam logic [OPAC_W-1:0] OPACITY_FULL = 9'd256;
  localparam logic [8:0]        Y_KNEE       = 9'd288;

  // After the weight multipliers
  typedef struct packed {
    logic [16:0]      lp;   // luma product, up to 256*256
    logic [8:0]       wu;   // chroma weights, 0..256
    logic [8:0]       wv;
    logic [PIX_W-1:0] by;
    logic [PIX_W-1:0] bu;
    logic [PIX_W-1:0] bv;
    logic [PIX_W-1:0] oy;
    logic [PIX_W-1:0] ou;
    logic [PIX_W-1:0] ov;
  } s1_t;

  // After the blend; chroma is unclamped, -128..382
  typedef struct packed {
    logic [8:0]        y;
    logic signed [9:0] u;
    logic signed [9:0] v;
  } s2_t;

endpackage

// ----- rtl/mayb_pix_if.sv -----
// Input pixel channel: base, overlay and mask samples with valid/ready.
// Depends on mayb_pkg.
interface mayb_pix_if import mayb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] base_y;
  logic [PIX_W-1:0] base_u;
  logic [PIX_W-1:0] base_v;
  logic [PIX_W-1:0] over_y;
  logic [PIX_W-1:0] over_u;
  logic [PIX_W-1:0] over_v;
  logic [PIX_W-1:0] mask_luma;
  logic [PIX_W-1:0] mask_u;
  logic [PIX_W-1:0] mask_v;

  modport source (output valid, base_y, base_u, base_v, over_y, over_u, over_v,
                  mask_luma, mask_u, mask_v, input ready);
  modport sink   (input valid, base_y, base_u, base_v, over_y, over_u, over_v,
                  mask_luma, mask_u, mask_v, output ready);
endinterface

// ----- rtl/mayb_res_if.sv -----
// Result pixel channel: blended Y, U, V with valid/ready.
// Depends on mayb_pkg.
interface mayb_res_if import mayb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_y;
  logic [PIX_W-1:0] out_u;
  logic [PIX_W-1:0] out_v;

  modport source (output valid, out_y, out_u, out_v, input ready);
  modport sink   (input valid, out_y, out_u, out_v, output ready);
endinterface

// ----- rtl/masked_additive_yuv_blend.sv -----
// Masked additive overlay blend, YUV 4:4:4, three-stage pipeline.
// Depends on mayb_pkg, mayb_pix_if and mayb_res_if.
//
//  channel   dir  handshake      payload
//  -------   ---  -------------  ------------------------------------------------
//  pix       in   valid/ready    base_y/u/v, over_y/u/v, mask_luma/u/v (8b each)
//  result    out  valid/ready    out_y, out_u, out_v (8b each)
//  wr_*      in   wr_en only     wr_index (0 opacity, 1 mask_enable), wr_data 9b
//
// One pixel per clock sustained while result.ready stays high; three register
// stages (weights, blend, desaturate/clamp), the first loaded at the accepting
// edge, with result.valid raised once the pixel has reached the third stage.
// Each stage holds only when it is full and the stage after it cannot take its
// transaction, so bubbles collapse and pix.ready stays high while a finished
// result waits, as long as an earlier stage is empty.
// Synchronous reset clears the stage valid bits and sets opacity 256, mask on.
module masked_additive_yuv_blend import mayb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  mayb_pix_if.sink              pix,
  mayb_res_if.source            result,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [OPAC_W-1:0] opacity;
  logic              mask_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      opacity     <= OPACITY_FULL;
      mask_enable <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        REG_OPACITY:     opacity     <= wr_data[OPAC_W-1:0];
        REG_MASK_ENABLE: mask_enable <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Values above full strength count as full strength
  logic [OPAC_W-1:0] op_sat;
  assign op_sat = (opacity > OPACITY_FULL) ? OPACITY_FULL : opacity;

  // ---------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its contents move on
  // ---------------------------------------------------------------------------
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3       = !v3 || result.ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign pix.ready = en1;

  // ---------------------------------------------------------------------------
  // Stage 1: mask x opacity weights
  // ---------------------------------------------------------------------------
  s1_t         s1, s1_next;
  logic [15:0] prod_u, prod_v;

  always_comb begin
    prod_u     = 16'(pix.mask_u * op_sat);
    prod_v     = 16'(pix.mask_v * op_sat);
    s1_next.by = pix.base_y;
    s1_next.bu = pix.base_u;
    s1_next.bv = pix.base_v;
    s1_next.oy = pix.over_y;
    s1_next.ou = pix.over_u;
    s1_next.ov = pix.over_v;
    if (mask_enable) begin
      s1_next.lp = 17'(pix.mask_luma * op_sat);
      s1_next.wu = {1'b0, prod_u[15:8]};
      s1_next.wv = {1'b0, prod_v[15:8]};
    end else begin
      s1_next.lp = {op_sat, 8'd0};
      s1_next.wu = op_sat;
      s1_next.wv = op_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= pix.valid;
    end
    if (en1) begin
      s1 <= s1_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: weighted luma add and chroma pull toward neutral
  // ---------------------------------------------------------------------------
  function automatic logic signed [9:0] chroma_mix(input logic [7:0] b,
                                                   input logic [7:0] ov,
                                                   input logic [8:0] w);
    logic [8:0]  inv;
    logic [16:0] mix;
    begin
      inv = 9'd256 - w;
      mix = {1'b0, inv, 7'd0} + 17'(w * ov);   // at most 65280
      chroma_mix = signed'({2'b00, b}) + signed'({2'b00, mix[15:8]}) - 10'sd128;
    end
  endfunction

  s2_t         s2, s2_next;
  logic [24:0] yprod;

  always_comb begin
    yprod      = 25'(s1.lp * s1.oy);
    s2_next.y  = {1'b0, s1.by} + yprod[24:16];
    s2_next.u  = chroma_mix(s1.bu, s1.ou, s1.wu);
    s2_next.v  = chroma_mix(s1.bv, s1.ov, s1.wv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      s2 <= s2_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: overbright desaturation, clamps, output register
  // ---------------------------------------------------------------------------
  // floor((c*m + 128*(32-m)) / 32); magnitudes stay well inside 16 bits
  function automatic logic signed [15:0] desat(input logic signed [9:0] c,
                                               input logic [5:0] m);
    logic signed [15:0] prod;
    logic signed [15:0] sum;
    begin
      prod  = 16'(signed'({{6{c[9]}}, c}) * signed'({10'd0, m}));
      sum   = prod + signed'({3'd0, 6'd32 - m, 7'd0});
      desat = sum >>> 5;
    end
  endfunction

  function automatic logic [7:0] sat8(input logic signed [15:0] x);
    begin
      if (x < 0)             sat8 = 8'd0;
      else if (x > 16'sd255) sat8 = 8'd255;
      else                   sat8 = x[7:0];
    end
  endfunction

  logic               overbright;
  logic [5:0]         knee_m;
  logic signed [15:0] u_pre, v_pre;
  logic [7:0]         y_next, u_next, v_next;
  logic [7:0]         y_q, u_q, v_q;

  always_comb begin
    overbright = s2.y[8];                    // y > 255
    knee_m     = (s2.y <= Y_KNEE) ? 6'(Y_KNEE - s2.y) : 6'd0;
    if (overbright) begin
      u_pre  = desat(s2.u, knee_m);
      v_pre  = desat(s2.v, knee_m);
      y_next = 8'hFF;
    end else begin
      u_pre  = 16'(s2.u);
      v_pre  = 16'(s2.v);
      y_next = s2.y[7:0];
    end
    u_next = sat8(u_pre);
    v_next = sat8(v_pre);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      y_q <= y_next;
      u_q <= u_next;
      v_q <= v_next;
    end
  end

  assign result.valid = v3;
  assign result.out_y = y_q;
  assign result.out_u = u_q;
  assign result.out_v = v_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Overbright luma always leaves the pipe clipped
  a_y_clip: assert property (@(posedge clk) disable iff (rst)
    (en3 && v2 && s2.y[8]) |=> (result.out_y == 8'hFF))
    else $error("overbright luma not clipped");

  // An empty pipe must take a transaction
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!v1 && !v2 && !v3) |-> pix.ready)
    else $error("empty pipeline refuses input");

  // A blocked middle stage keeps its transaction
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !en3) |=> (v2 && $stable(s2)))
    else $error("stage 2 lost a stalled transaction");

  // Chroma weights never exceed full strength
  a_weight: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (s1.wu <= 9'd256 && s1.wv <= 9'd256))
    else $error("chroma weight out of range");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for masked_additive_yuv_blend: random and directed pixels,
// per-field checks against an in-bench blend predictor, random stalls on both channels.
// Depends on mayb_pkg, mayb_pix_if, mayb_res_if and the RTL top level.
module testbench;
  import mayb_pkg::*;

  localparam int unsigned PHASE_PIXELS = 150;
  localparam int unsigned NUM_PHASES   = 13;
  localparam int unsigned STALL_MAX    = 18;
  // No transaction on either channel for this long means the block is stuck.
  // The slowest legal gap comes from the sender and receiver stalls plus the pipeline depth.
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [PIX_W-1:0] base_y;
    logic [PIX_W-1:0] base_u;
    logic [PIX_W-1:0] base_v;
    logic [PIX_W-1:0] over_y;
    logic [PIX_W-1:0] over_u;
    logic [PIX_W-1:0] over_v;
    logic [PIX_W-1:0] mask_luma;
    logic [PIX_W-1:0] mask_u;
    logic [PIX_W-1:0] mask_v;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
  } yuv_t;

  // Idling styles: none, occasional, full random on every transaction
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_t;

  logic clk;
  logic rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  mayb_pix_if pix_ch ();
  mayb_res_if res_ch ();

  masked_additive_yuv_blend i_dut (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix_ch),
    .result   (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Bench copy of the configuration registers
  logic [OPAC_W-1:0] cfg_opacity;
  logic              cfg_mask_en;

  pixel_t     pixels_pending[$];   // filled by the stimulus, drained by the driver
  yuv_t       blend_expected[$];   // predicted results, oldest first
  pixel_t     pix_on_bus;
  idle_mode_t send_idle;
  idle_mode_t recv_idle;

  int unsigned pixels_queued;
  int unsigned pixels_taken;
  int unsigned results_seen;
  int unsigned err_cnt;
  int unsigned idle_cycles;
  int          send_gap;
  int          recv_stall;
  bit          pix_fired;          // set at the edge a pixel transaction completes
  bit          res_fired;          // set at the edge a result transaction completes

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: one pixel through the blend with the current register copy
  // ---------------------------------------------------------------------------
  function automatic int clamp_byte(int x);
    if (x < 0) return 0;
    if (x > 255) return 255;
    return x;
  endfunction

  function automatic int pull_chroma(int b, int o, int w);
    // weight pulls the overlay toward neutral, then added as an offset from 128
    return b + ((128 * (256 - w) + w * o) >>> 8) - 128;
  endfunction

  function automatic yuv_t predict_blend(pixel_t p);
    int   op, lp, wu, wv, y, u, v, m;
    yuv_t r;
    // register values above full strength act as full strength
    op = (cfg_opacity > OPACITY_FULL) ? 256 : int'(cfg_opacity);
    if (cfg_mask_en) begin
      lp = int'(p.mask_luma) * op;
      wu = (int'(p.mask_u) * op) >>> 8;
      wv = (int'(p.mask_v) * op) >>> 8;
    end else begin
      lp = 256 * op;
      wu = op;
      wv = op;
    end
    y = int'(p.base_y) + ((lp * int'(p.over_y)) >>> 16);
    u = pull_chroma(int'(p.base_u), int'(p.over_u), wu);
    v = pull_chroma(int'(p.base_v), int'(p.over_v), wv);
    if (y > 255) begin
      // overbright: fade chroma toward neutral, fully neutral at 288 and above
      m = 288 - y;
      if (m < 0) m = 0;
      u = (u * m + 128 * (32 - m)) >>> 5;   // arithmetic, i.e. floor
      v = (v * m + 128 * (32 - m)) >>> 5;
      y = 255;
    end
    r.y = y[PIX_W-1:0];
    r.u = PIX_W'(clamp_byte(u));
    r.v = PIX_W'(clamp_byte(v));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int draw_gap(idle_mode_t mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 5) == 0) ? $urandom_range(0, STALL_MAX) : 0;
      default:     return $urandom_range(0, STALL_MAX);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t mk_pixel(int by, int bu, int bv, int oy, int ou, int ov,
                                      int my, int mu, int mv);
    pixel_t p;
    p = '{base_y: PIX_W'(by), base_u: PIX_W'(bu), base_v: PIX_W'(bv),
          over_y: PIX_W'(oy), over_u: PIX_W'(ou), over_v: PIX_W'(ov),
          mask_luma: PIX_W'(my), mask_u: PIX_W'(mu), mask_v: PIX_W'(mv)};
    return p;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = '{base_y: rand_sample(), base_u: rand_sample(), base_v: rand_sample(),
          over_y: rand_sample(), over_u: rand_sample(), over_v: rand_sample(),
          mask_luma: rand_sample(), mask_u: rand_sample(), mask_v: rand_sample()};
    // a quarter of pixels pushed toward overbright, where the fade logic lives
    if ($urandom_range(0, 3) == 0) begin
      p.base_y    = PIX_W'($urandom_range(180, 255));
      p.over_y    = PIX_W'($urandom_range(0, 255));
      p.mask_luma = PIX_W'($urandom_range(128, 255));
    end
    return p;
  endfunction

  task automatic queue_pixel(pixel_t p);
    pixels_pending.push_back(p);
    pixels_queued++;
  endtask

  // Registers only change once the pipeline is empty
  task automatic wait_drained();
    while (results_seen != pixels_queued) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    @(negedge clk);
    wr_en    = 1'b0;
    if (idx == REG_OPACITY) cfg_opacity = data[OPAC_W-1:0];
    else                    cfg_mask_en = data[0];
  endtask

  task automatic set_blend(int opac, bit men);
    write_reg(REG_OPACITY, CFG_DATA_W'(opac));
    // spare high bits toggle on the mask write too
    write_reg(REG_MASK_ENABLE, {8'($urandom_range(0, 255)), men});
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: changes inputs on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (pix_ch.valid && !pix_fired) begin
      // hold the transaction until it is taken
    end else begin
      if (pix_fired) begin
        pix_fired = 1'b0;
        send_gap  = draw_gap(send_idle);
      end
      if (send_gap > 0 || pixels_pending.size() == 0) begin
        if (send_gap > 0) send_gap--;
        pix_ch.valid <= 1'b0;
      end else begin
        pix_on_bus          = pixels_pending.pop_front();
        pix_ch.valid       <= 1'b1;
        pix_ch.base_y      <= pix_on_bus.base_y;
        pix_ch.base_u      <= pix_on_bus.base_u;
        pix_ch.base_v      <= pix_on_bus.base_v;
        pix_ch.over_y      <= pix_on_bus.over_y;
        pix_ch.over_u      <= pix_on_bus.over_u;
        pix_ch.over_v      <= pix_on_bus.over_v;
        pix_ch.mask_luma   <= pix_on_bus.mask_luma;
        pix_ch.mask_u      <= pix_on_bus.mask_u;
        pix_ch.mask_v      <= pix_on_bus.mask_v;
      end
    end
  end

  // Result sink: ready drops for a random stall after each transaction
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_fired) begin
        res_fired  = 1'b0;
        recv_stall = draw_gap(recv_idle);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // ---------------------------------------------------------------------------
  function automatic bit field_ok(string name, logic [PIX_W-1:0] exp_v,
                                  logic [PIX_W-1:0] act_v);
    if (exp_v === act_v) return 1'b1;
    if (err_cnt < MAX_REPORTS)
      $display("mismatch on result %0d, %s: expected %0d, got %0d",
               results_seen, name, exp_v, act_v);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    yuv_t exp_px;
    bit   ok;
    if (!rst) begin
      if (pix_ch.valid && pix_ch.ready) begin
        blend_expected.push_back(predict_blend(pix_on_bus));
        pixels_taken++;
        pix_fired = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        res_fired = 1'b1;
        if (blend_expected.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display("result with no pixel outstanding: y %0d u %0d v %0d",
                     res_ch.out_y, res_ch.out_u, res_ch.out_v);
          err_cnt++;
        end else begin
          exp_px = blend_expected.pop_front();
          ok = field_ok("out_y", exp_px.y, res_ch.out_y);
          ok = field_ok("out_u", exp_px.u, res_ch.out_u) && ok;
          ok = field_ok("out_v", exp_px.v, res_ch.out_v) && ok;
          if (!ok) err_cnt++;
        end
        results_seen++;
      end
    end
  end

  // Watchdog on channel activity
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("masked_additive_yuv_blend regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    pixel_t directed[$];
    int     opac;

    clk           = 1'b0;
    rst           = 1'b1;
    wr_en         = 1'b0;
    wr_index      = '0;
    wr_data       = '0;
    pix_ch.valid  = 1'b0;
    pix_ch.base_y = '0; pix_ch.base_u = '0; pix_ch.base_v = '0;
    pix_ch.over_y = '0; pix_ch.over_u = '0; pix_ch.over_v = '0;
    pix_ch.mask_luma = '0; pix_ch.mask_u = '0; pix_ch.mask_v = '0;
    res_ch.ready  = 1'b0;
    cfg_opacity   = OPACITY_FULL;   // reset values
    cfg_mask_en   = 1'b1;
    send_idle     = IDLE_NONE;
    recv_idle     = IDLE_NONE;
    send_gap      = 0;
    recv_stall    = 0;
    pix_fired     = 1'b0;
    res_fired     = 1'b0;
    pixels_queued = 0;
    pixels_taken  = 0;
    results_seen  = 0;
    err_cnt       = 0;
    idle_cycles   = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed pixels: field extremes, chroma pushed past both rails,
    // luma just at and just past the overbright threshold, and deep overbright
    directed.push_back(mk_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_pixel(255, 255, 255, 255, 255, 255, 255, 255, 255));
    directed.push_back(mk_pixel(250, 0, 255, 20, 0, 255, 255, 255, 255));
    directed.push_back(mk_pixel(128, 128, 128, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_pixel(100, 255, 0, 50, 255, 0, 128, 255, 255));
    directed.push_back(mk_pixel(255, 10, 240, 1, 200, 30, 255, 255, 255));
    directed.push_back(mk_pixel(255, 10, 240, 2, 200, 30, 255, 1, 254));

    // First pass under reset values, then full strength unmasked,
    // out-of-range opacity, and zero opacity
    for (int c = 0; c < 4; c++) begin
      case (c)
        1: set_blend(256, 1'b0);
        2: set_blend(511, 1'b1);
        3: set_blend(0, 1'b1);
        default: ;
      endcase
      foreach (directed[i]) queue_pixel(directed[i]);
      wait_drained();
    end

    // Random phases; every phase boundary also stalls the sender until the
    // pipeline has emptied
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       opac = 0;
        1:       opac = 256;
        2:       opac = 511;
        3:       opac = 1;
        4:       opac = 257;
        5:       opac = 255;
        default: opac = $urandom_range(0, 511);
      endcase
      set_blend(opac, (ph < 3) ? ph[0] : 1'($urandom_range(0, 1)));
      send_idle = idle_mode_t'(ph % 3);
      recv_idle = idle_mode_t'((ph / 3) % 3);
      for (int n = 0; n < PHASE_PIXELS; n++) queue_pixel(rand_pixel());
      wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && blend_expected.size() == 0) begin
      $display("masked_additive_yuv_blend regression: pass");
    end else begin
      $display("masked_additive_yuv_blend regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mayb_pkg.sv
rtl/mayb_pix_if.sv
rtl/mayb_res_if.sv
rtl/masked_additive_yuv_blend.sv
dv/testbench.sv
